@@ rtl/core/humidity_temp_frame_decoder_top_assert.svh @@
// Assertion macros shared by the frame decoder RTL
`ifndef HUMIDITY_TEMP_FRAME_DECODER_TOP_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define HTFD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("htfd same-cycle check failed");

// Next-cycle implication, checked out of reset
`define HTFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("htfd next-cycle check failed");

`endif

@@ rtl/core/htfd_pkg.sv @@
// Shared constants, types and the CRC-8 step function for the frame decoder
package htfd_pkg;

   // CRC-8, polynomial x^8+x^5+x^4+1, preset all ones, no final XOR
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // Byte position within a reply
   localparam logic [2:0] IDX_TMSB = 3'd0;
   localparam logic [2:0] IDX_TLSB = 3'd1;
   localparam logic [2:0] IDX_TCRC = 3'd2;
   localparam logic [2:0] IDX_HMSB = 3'd3;
   localparam logic [2:0] IDX_HLSB = 3'd4;
   localparam logic [2:0] IDX_HCRC = 3'd5;

   // Scaling: raw * gain / 65535
   localparam int PROD_W = 31;
   localparam int QUOT_W = 15;
   localparam logic [14:0] TEMP_GAIN  = 15'd17500;
   localparam logic [13:0] HUMID_GAIN = 14'd10000;
   localparam logic [16:0] DIV_DEN    = 17'd65535;

   // Temperature offset and output limits, hundredths of a degree
   localparam logic signed [15:0] TEMP_BASE = -16'sd4500;
   localparam logic signed [15:0] TEMP_MIN  = -16'sd5500;
   localparam logic signed [15:0] TEMP_MAX  = 16'sd14000;

   // What the frame tracker hands to the output stage
   typedef struct packed {
      logic        produce;
      logic        temp_ok;
      logic        humid_ok;
      logic [14:0] temp_scaled;
      logic [13:0] humid_scaled;
   } frame_status_type;

   // One byte through the CRC, MSB first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ rtl/core/htfd_div.sv @@
// Exact floor division of a scaled word by 65535, one correction step
module htfd_div (
   input  logic [htfd_pkg::PROD_W-1:0] product,
   output logic [htfd_pkg::QUOT_W-1:0] quotient
);

   logic [htfd_pkg::QUOT_W-1:0] q_est;
   logic [16:0]                 rem;

   // x/65536 underestimates by at most one; remainder stays below 2*65535
   assign q_est    = product[htfd_pkg::PROD_W-1:16];
   assign rem      = {1'b0, product[15:0]} + 17'(q_est);
   assign quotient = (rem >= htfd_pkg::DIV_DEN) ? q_est + 15'd1 : q_est;

endmodule

@@ rtl/core/htfd_frame.sv @@
// Reply byte tracker: position counter, CRC check, word assembly and scaling
module htfd_frame (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [7:0]                 frame_byte,
   input  logic                       frame_start,
   output htfd_pkg::frame_status_type status
);

   logic [2:0]  byte_index_ff, byte_index_in;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] word_ff, word_in;
   logic [14:0] temp_scaled_ff, temp_scaled_in;
   logic        temp_ok_ff, temp_ok_in;
   logic [2:0]  idx;
   logic [htfd_pkg::PROD_W-1:0] temp_prod, humid_prod;
   logic [htfd_pkg::QUOT_W-1:0] temp_quot, humid_quot;

   // Start flag or an out-of-range count restarts the reply
   assign idx = (frame_start || (byte_index_ff > htfd_pkg::IDX_HCRC)) ?
                htfd_pkg::IDX_TMSB : byte_index_ff;

   // Scaling of the assembled word
   assign temp_prod  = 31'(word_ff) * 31'(htfd_pkg::TEMP_GAIN);
   assign humid_prod = 31'(word_ff) * 31'(htfd_pkg::HUMID_GAIN);

   htfd_div u_temp_div (
      .product  (temp_prod),
      .quotient (temp_quot)
   );

   htfd_div u_humid_div (
      .product  (humid_prod),
      .quotient (humid_quot)
   );

   // Next state per byte position
   always_comb begin
      crc_in         = crc_ff;
      word_in        = word_ff;
      temp_scaled_in = temp_scaled_ff;
      temp_ok_in     = temp_ok_ff;
      byte_index_in  = (idx == htfd_pkg::IDX_HCRC) ? htfd_pkg::IDX_TMSB : idx + 3'd1;
      case (idx)
         htfd_pkg::IDX_TMSB, htfd_pkg::IDX_HMSB: begin
            crc_in  = htfd_pkg::crc8_byte(htfd_pkg::CRC_INIT, frame_byte);
            word_in = {word_ff[7:0], frame_byte};
         end
         htfd_pkg::IDX_TLSB, htfd_pkg::IDX_HLSB: begin
            crc_in  = htfd_pkg::crc8_byte(crc_ff, frame_byte);
            word_in = {word_ff[7:0], frame_byte};
         end
         htfd_pkg::IDX_TCRC: begin
            temp_ok_in     = (frame_byte == crc_ff);
            temp_scaled_in = temp_quot;
            crc_in         = htfd_pkg::CRC_INIT;
         end
         htfd_pkg::IDX_HCRC: begin
            crc_in = htfd_pkg::CRC_INIT;
         end
         default: begin
            crc_in = crc_ff;
         end
      endcase
   end

   // State registers, updated once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff  <= htfd_pkg::IDX_TMSB;
         crc_ff         <= htfd_pkg::CRC_INIT;
         word_ff        <= '0;
         temp_scaled_ff <= '0;
         temp_ok_ff     <= 1'b0;
      end else if (step) begin
         byte_index_ff  <= byte_index_in;
         crc_ff         <= crc_in;
         word_ff        <= word_in;
         temp_scaled_ff <= temp_scaled_in;
         temp_ok_ff     <= temp_ok_in;
      end
   end

   // Result indication on the humidity CRC byte
   assign status.produce      = step && (idx == htfd_pkg::IDX_HCRC);
   assign status.temp_ok      = temp_ok_ff;
   assign status.humid_ok     = (frame_byte == crc_ff);
   assign status.temp_scaled  = temp_scaled_ff;
   assign status.humid_scaled = humid_quot[13:0];

endmodule

@@ rtl/core/humidity_temp_frame_decoder_top.sv @@
// Top level: input register, frame tracker, offset/saturation and result register
// The result for the sixth byte of a reply passes the input register and then the result
//   register, and shows on rsp_valid once it is loaded there.
// Throughput: one byte per cycle; a result held by rsp_stall also holds the input.
// Reset (synchronous): byte counter to first byte, CRC to 0xFF, offset to 0,
//   both registers empty.
`include "humidity_temp_frame_decoder_top_assert.svh"

module humidity_temp_frame_decoder_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_frame_byte,
   input  logic               req_frame_start,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [14:0] rsp_temp_centi,
   output logic [13:0]        rsp_humid_centi,
   output logic               rsp_temp_valid,
   output logic               rsp_humid_valid,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic signed [10:0] csr_temp_offset_centi
);

   logic                       in_valid_ff, in_valid_in;
   logic [7:0]                 in_byte_ff;
   logic                       in_start_ff;
   logic signed [10:0]         offset_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [14:0]         rsp_temp_ff;
   logic [13:0]                rsp_humid_ff;
   logic                       rsp_tvalid_ff, rsp_hvalid_ff;
   logic                       req_accept, advance, load_rsp;
   logic signed [15:0]         temp_sum, temp_sat;
   htfd_pkg::frame_status_type status;

   // Handshake: the held item moves on when the result register can take a result
   assign advance     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign req_accept  = req_valid && !req_stall;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);
   assign load_rsp    = status.produce;
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);
   assign csr_ready   = 1'b1;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff  <= req_frame_byte;
         in_start_ff <= req_frame_start;
      end
   end

   // Offset register
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         offset_ff <= csr_temp_offset_centi;
      end
   end

   htfd_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .frame_byte  (in_byte_ff),
      .frame_start (in_start_ff),
      .status      (status)
   );

   // Temperature: base + scaled + offset, clamped to the output range
   assign temp_sum = htfd_pkg::TEMP_BASE + $signed({1'b0, status.temp_scaled})
                     + 16'(offset_ff);
   assign temp_sat = (temp_sum < htfd_pkg::TEMP_MIN) ? htfd_pkg::TEMP_MIN :
                     (temp_sum > htfd_pkg::TEMP_MAX) ? htfd_pkg::TEMP_MAX : temp_sum;

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_temp_ff   <= status.temp_ok ? temp_sat[14:0] : '0;
         rsp_humid_ff  <= status.humid_ok ? status.humid_scaled : '0;
         rsp_tvalid_ff <= status.temp_ok;
         rsp_hvalid_ff <= status.humid_ok;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temp_centi  = rsp_temp_ff;
   assign rsp_humid_centi = rsp_humid_ff;
   assign rsp_temp_valid  = rsp_tvalid_ff;
   assign rsp_humid_valid = rsp_hvalid_ff;

   // Checks
   `HTFD_ASSERT_NOW(a_temp_zero_when_bad, clock, reset,
      rsp_valid && !rsp_temp_valid, rsp_temp_centi == 15'sd0)
   `HTFD_ASSERT_NOW(a_humid_zero_when_bad, clock, reset,
      rsp_valid && !rsp_humid_valid, rsp_humid_centi == 14'd0)
   `HTFD_ASSERT_NOW(a_humid_range, clock, reset, rsp_valid, rsp_humid_centi <= 14'd10000)
   `HTFD_ASSERT_NOW(a_temp_range, clock, reset, rsp_valid,
      (rsp_temp_centi >= -15'sd5500) && (rsp_temp_centi <= 15'sd14000))
   `HTFD_ASSERT_NEXT(a_item_held, clock, reset, in_valid_ff && !advance, in_valid_ff)

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the humidity/temperature sensor frame decoder
`timescale 1ns / 100ps

module tb_top;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 78;

   // One decoded reading, as it leaves the block
   typedef struct packed {
      logic signed [14:0] temp;
      logic [13:0]        humid;
      logic               temp_ok;
      logic               humid_ok;
   } sensor_reading_type;

   // Where a directed byte comes from
   typedef enum logic [1:0] {SRC_DATA, SRC_CRC_GOOD, SRC_CRC_BAD} byte_src_type;

   typedef struct {
      logic               cfg_wr;
      logic signed [10:0] cfg_val;
      byte_src_type       src;
      logic [7:0]         data;
      logic               start;
      logic               has_exp;
      sensor_reading_type exp;
   } dir_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_frame_byte = 8'h00;
   logic               req_frame_start = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [14:0] rsp_temp_centi;
   logic [13:0]        rsp_humid_centi;
   logic               rsp_temp_valid;
   logic               rsp_humid_valid;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic signed [10:0] csr_temp_offset_centi = 11'sd0;

   // Decoder shadow state
   logic [2:0]         dec_pos = htfd_pkg::IDX_TMSB;
   logic [7:0]         dec_crc = htfd_pkg::CRC_INIT;
   logic [15:0]        dec_word = 16'h0000;
   logic [15:0]        dec_temp_word = 16'h0000;
   logic               dec_temp_ok = 1'b0;
   logic signed [10:0] dec_offset = 11'sd0;

   sensor_reading_type pending_readings[$];
   dir_row_type        dir_rows[$];
   int                 error_count = 0;
   int                 idle_cycles = 0;
   int                 sender_idle_pct = 0;
   int                 recv_stall_pct = 0;

   humidity_temp_frame_decoder_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_frame_byte        (req_frame_byte),
      .req_frame_start       (req_frame_start),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_temp_centi        (rsp_temp_centi),
      .rsp_humid_centi       (rsp_humid_centi),
      .rsp_temp_valid        (rsp_temp_valid),
      .rsp_humid_valid       (rsp_humid_valid),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_temp_offset_centi (csr_temp_offset_centi)
   );

   always #2 clock = ~clock;

   // CRC-8 worked bit-serially, data MSB first
   function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] d);
      logic [7:0] r;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
         if (r[7] ^ d[i]) begin
            r = {r[6:0], 1'b0} ^ htfd_pkg::CRC_POLY;
         end else begin
            r = {r[6:0], 1'b0};
         end
      end
      return r;
   endfunction

   // Advance the shadow decoder by one byte; returns 1 when a reading is due
   function automatic logic decode_reply_byte(input logic [7:0] b, input logic s,
                                              output sensor_reading_type r);
      logic [2:0] pos;
      logic       h_ok;
      int         t;
      int         h;
      pos = s ? htfd_pkg::IDX_TMSB : dec_pos;
      if (pos > htfd_pkg::IDX_HCRC) pos = htfd_pkg::IDX_TMSB;
      r = '0;
      decode_reply_byte = 1'b0;
      case (pos)
         htfd_pkg::IDX_TMSB, htfd_pkg::IDX_HMSB: begin
            dec_crc  = crc8_update(htfd_pkg::CRC_INIT, b);
            dec_word = {dec_word[7:0], b};
         end
         htfd_pkg::IDX_TLSB, htfd_pkg::IDX_HLSB: begin
            dec_crc  = crc8_update(dec_crc, b);
            dec_word = {dec_word[7:0], b};
         end
         htfd_pkg::IDX_TCRC: begin
            dec_temp_ok   = (b == dec_crc);
            dec_temp_word = dec_word;
            dec_crc       = htfd_pkg::CRC_INIT;
         end
         default: begin
            h_ok = (b == dec_crc);
            t = 0;
            h = 0;
            // bad CRC forces the field to zero
            if (dec_temp_ok) begin
               t = -4500 + (17500 * int'(dec_temp_word)) / 65535 + int'(dec_offset);
               if (t < -5500) t = -5500;
               if (t > 14000) t = 14000;
            end
            if (h_ok) h = (10000 * int'(dec_word)) / 65535;
            r.temp     = 15'(t);
            r.humid    = 14'(h);
            r.temp_ok  = dec_temp_ok;
            r.humid_ok = h_ok;
            dec_crc    = htfd_pkg::CRC_INIT;
            decode_reply_byte = 1'b1;
         end
      endcase
      dec_pos = (pos >= htfd_pkg::IDX_HCRC) ? htfd_pkg::IDX_TMSB : pos + 3'd1;
   endfunction

   function automatic sensor_reading_type mk_reading(input int t, input int h,
                                                     input logic tv, input logic hv);
      sensor_reading_type r;
      r.temp     = 15'(t);
      r.humid    = 14'(h);
      r.temp_ok  = tv;
      r.humid_ok = hv;
      return r;
   endfunction

   function automatic void add_row(input logic cfg_wr, input logic signed [10:0] cfg_val,
                                   input byte_src_type src, input logic [7:0] data,
                                   input logic start, input logic has_exp,
                                   input sensor_reading_type exp);
      dir_row_type row;
      row.cfg_wr  = cfg_wr;
      row.cfg_val = cfg_val;
      row.src     = src;
      row.data    = data;
      row.start   = start;
      row.has_exp = has_exp;
      row.exp     = exp;
      dir_rows.push_back(row);
   endfunction

   // Six rows of one reply, typed expectation on the last byte
   function automatic void add_frame(input logic cfg_wr, input logic signed [10:0] cfg_val,
                                     input logic start, input logic [15:0] tw,
                                     input logic t_good, input logic [15:0] hw,
                                     input logic h_good, input sensor_reading_type exp);
      add_row(cfg_wr, cfg_val, SRC_DATA, tw[15:8], start, 1'b0, '0);
      add_row(1'b0, 11'sd0, SRC_DATA, tw[7:0], 1'b0, 1'b0, '0);
      add_row(1'b0, 11'sd0, t_good ? SRC_CRC_GOOD : SRC_CRC_BAD, 8'h00, 1'b0, 1'b0, '0);
      add_row(1'b0, 11'sd0, SRC_DATA, hw[15:8], 1'b0, 1'b0, '0);
      add_row(1'b0, 11'sd0, SRC_DATA, hw[7:0], 1'b0, 1'b0, '0);
      add_row(1'b0, 11'sd0, h_good ? SRC_CRC_GOOD : SRC_CRC_BAD, 8'h00, 1'b0, 1'b1, exp);
   endfunction

   // Offer one byte, hold it until taken, then predict
   task automatic send_item(input logic [7:0] b, input logic s, input logic typed,
                            input sensor_reading_type typed_val);
      sensor_reading_type r;
      logic               made;
      while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_frame_byte  <= b;
      req_frame_start <= s;
      do @(posedge clock); while (req_stall);
      made = decode_reply_byte(b, s, r);
      if (made) pending_readings.push_back(typed ? typed_val : r);
   endtask

   // Reply, or its first nbytes bytes, from the given words; CRC bytes taken from the shadow CRC, good or spoilt
   task automatic send_frame(input logic start, input logic [15:0] tw, input logic [15:0] hw,
                             input logic t_good, input logic h_good, input int nbytes);
      logic [7:0] b;
      for (int i = 0; i < nbytes; i++) begin
         case (i)
            0: b = tw[15:8];
            1: b = tw[7:0];
            2: b = t_good ? dec_crc : dec_crc ^ 8'($urandom_range(1, 255));
            3: b = hw[15:8];
            4: b = hw[7:0];
            default: b = h_good ? dec_crc : dec_crc ^ 8'($urandom_range(1, 255));
         endcase
         send_item(b, (i == 0) ? start : 1'b0, 1'b0, '0);
      end
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Offset write, only once the block has drained
   task automatic write_offset(input logic signed [10:0] v);
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid             <= 1'b1;
      csr_temp_offset_centi <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      dec_offset = v;
   endtask

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Result checker
   always @(posedge clock) begin
      sensor_reading_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            $error("unexpected reading: temp_centi %0d humid_centi %0d",
                   rsp_temp_centi, rsp_humid_centi);
            error_count++;
         end else begin
            e = pending_readings.pop_front();
            if (rsp_temp_centi !== e.temp) begin
               $error("temp_centi: expected %0d, got %0d", e.temp, rsp_temp_centi);
               error_count++;
            end
            if (rsp_humid_centi !== e.humid) begin
               $error("humid_centi: expected %0d, got %0d", e.humid, rsp_humid_centi);
               error_count++;
            end
            if (rsp_temp_valid !== e.temp_ok) begin
               $error("temp_valid: expected %0b, got %0b", e.temp_ok, rsp_temp_valid);
               error_count++;
            end
            if (rsp_humid_valid !== e.humid_ok) begin
               $error("humid_valid: expected %0b, got %0b", e.humid_ok, rsp_humid_valid);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("humidity_temp_frame_decoder_top verification failed");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      logic [7:0]         b;
      logic signed [10:0] off;
      logic               st;
      int                 sent;
      int                 sel;
      int                 n;

      // directed replies: extremes, each CRC failing alone, resync, wrap, saturation
      add_frame(1'b0, 11'sd0, 1'b1, 16'h0000, 1'b1, 16'hFFFF, 1'b1,
                mk_reading(-4500, 10000, 1'b1, 1'b1));
      add_frame(1'b0, 11'sd0, 1'b0, 16'hFFFF, 1'b0, 16'hFFFF, 1'b1,
                mk_reading(0, 10000, 1'b0, 1'b1));
      // half a reply, then a fresh start cuts it off
      add_row(1'b1, 11'sd1023, SRC_DATA, 8'hA5, 1'b1, 1'b0, '0);
      add_row(1'b0, 11'sd0, SRC_DATA, 8'h5A, 1'b0, 1'b0, '0);
      add_frame(1'b0, 11'sd0, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0,
                mk_reading(14000, 0, 1'b1, 1'b0));
      add_frame(1'b1, -11'sd1024, 1'b0, 16'h0000, 1'b1, 16'h0000, 1'b1,
                mk_reading(-5500, 0, 1'b1, 1'b1));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].cfg_wr) write_offset(dir_rows[i].cfg_val);
         case (dir_rows[i].src)
            SRC_CRC_GOOD: b = dec_crc;
            SRC_CRC_BAD:  b = dec_crc ^ 8'hFF;
            default:      b = dir_rows[i].data;
         endcase
         send_item(b, dir_rows[i].start, dir_rows[i].has_exp, dir_rows[i].exp);
      end

      // random phases, each with its own offset and idling mix
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: off = 11'sd1023;
            1: off = -11'sd1024;
            2: off = 11'sd0;
            3: off = -11'sd1000;
            4: off = 11'sd1000;
            default: off = 11'($urandom_range(0, 2047));
         endcase
         write_offset(off);
         case (ph % 4)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin sender_idle_pct = 25; recv_stall_pct = 25; end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            sel = $urandom_range(0, 99);
            // keep most replies aligned: force a start when mid-reply
            st = (dec_pos != htfd_pkg::IDX_TMSB) ? 1'b1 : 1'($urandom_range(0, 1));
            if (sel < 80) begin
               send_frame(st, pick_word(), pick_word(), $urandom_range(0, 99) < 85,
                          $urandom_range(0, 99) < 85, 6);
               sent += 6;
            end else if (sel < 90) begin
               n = $urandom_range(1, 5);
               send_frame(1'b1, pick_word(), pick_word(), 1'($urandom_range(0, 1)),
                          1'b1, n);
               sent += n;
            end else begin
               send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
               sent += 1;
            end
         end
      end

      // drain
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("humidity_temp_frame_decoder_top verification clean");
      end else begin
         $display("humidity_temp_frame_decoder_top verification failed");
      end
      $finish;
   end

endmodule
